### rtl/sofq_pkg.sv
// ----------------------------------------------------------------------------
// sofq_pkg
// Shared types and constants for the four-queue shared store: command and
// status codes, default queue depths, priority orders and the pick struct.
// ----------------------------------------------------------------------------
package sofq_pkg;

    // default queue depths
    localparam int Q1_DEPTH_DEF = 5;
    localparam int Q2_DEPTH_DEF = 3;
    localparam int Q3_DEPTH_DEF = 2;
    localparam int Q4_DEPTH_DEF = 6;

    // a fill counter holds 0..31
    localparam int FILL_W = 5;
    localparam int WORD_W = 32;

    // command codes
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_DELETE = 1'b1;

    // result status codes
    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } t_status;

    // queue priority orders, first entry is tried first
    localparam logic [1:0] INS_ORDER [4] = '{2'd2, 2'd1, 2'd0, 2'd3};
    localparam logic [1:0] DEL_ORDER [4] = '{2'd3, 2'd0, 2'd1, 2'd2};

    // outcome of the queue selection
    typedef struct packed {
        logic       found;
        logic [1:0] queue;
    } t_pick;

endpackage

### rtl/sofq_ram.sv
// ----------------------------------------------------------------------------
// sofq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sofq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/sofq_sel.sv
// ----------------------------------------------------------------------------
// sofq_sel
// Priority queue selection: the first queue with room for an insert, or the
// first non-empty queue for a delete, each in its own fixed order.
// ----------------------------------------------------------------------------
module sofq_sel import sofq_pkg::*; (
    input  logic       i_cmd,
    input  logic [3:0] i_full,
    input  logic [3:0] i_empty,
    output t_pick      o_pick
);

    logic [3:0] avail;
    t_pick      pick;

    // queues that can serve this command
    assign avail = (i_cmd == CMD_INSERT) ? ~i_full : ~i_empty;

    // walk the order backwards so the earliest candidate wins
    always_comb begin
        pick = '0;
        for (int k = 3; k >= 0; k--) begin
            if (i_cmd == CMD_INSERT) begin
                if (avail[INS_ORDER[k]]) begin
                    pick.found = 1'b1;
                    pick.queue = INS_ORDER[k];
                end
            end else begin
                if (avail[DEL_ORDER[k]]) begin
                    pick.found = 1'b1;
                    pick.queue = DEL_ORDER[k];
                end
            end
        end
    end

    assign o_pick = pick;

endmodule

### rtl/spill_order_four_queue_store_core.sv
// ----------------------------------------------------------------------------
// spill_order_four_queue_store_core
// Four FIFO queues laid out back to back in one shared word store. Inserts
// spill 3, 2, 1, 4; deletes pop 4, 1, 2, 3 and shift the queue down.
// ----------------------------------------------------------------------------
//
// channel   direction  signals                                  handshake
// command   in         i_command, i_value                       start & !busy
// result    out        o_status, o_queue_number, o_popped_value o_done strobe
//
// Insert, overflow and underflow: result strobes the cycle after the
// transaction, busy stays low, so one can follow every cycle.
// Delete of a queue holding f words: the read/shift sequencer walks all f words
// once through the store's read and write ports with busy high, and the result
// strobes in the cycle after the walk ends.
// Reset clears the fill counters and the sequencer; store contents are left.
// The receiver cannot stall: each result is valid for one cycle only.
// ----------------------------------------------------------------------------
module spill_order_four_queue_store_core import sofq_pkg::*; #(
    parameter int Q1_DEPTH = Q1_DEPTH_DEF,
    parameter int Q2_DEPTH = Q2_DEPTH_DEF,
    parameter int Q3_DEPTH = Q3_DEPTH_DEF,
    parameter int Q4_DEPTH = Q4_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              i_command,
    input  logic signed [31:0] i_value,
    output logic              o_done,
    output logic [1:0]        o_status,
    output logic [1:0]        o_queue_number,
    output logic signed [31:0] o_popped_value
);

    localparam int STORE_WORDS = Q1_DEPTH + Q2_DEPTH + Q3_DEPTH + Q4_DEPTH;
    localparam int ADDR_W = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;

    localparam logic [FILL_W-1:0] Q_DEPTH [4] = '{
        FILL_W'(Q1_DEPTH), FILL_W'(Q2_DEPTH), FILL_W'(Q3_DEPTH), FILL_W'(Q4_DEPTH)
    };
    localparam logic [ADDR_W-1:0] Q_BASE [4] = '{
        ADDR_W'(0),
        ADDR_W'(Q1_DEPTH),
        ADDR_W'(Q1_DEPTH + Q2_DEPTH),
        ADDR_W'(Q1_DEPTH + Q2_DEPTH + Q3_DEPTH)
    };

    typedef enum logic [1:0] {
        S_IDLE  = 2'b01,
        S_SHIFT = 2'b10
    } t_state;

    t_state                   r_state, n_state;
    logic [FILL_W-1:0]        r_fill [4];
    logic [FILL_W-1:0]        n_fill [4];
    logic [FILL_W-1:0]        r_cnt, n_cnt;
    logic [FILL_W-1:0]        r_len, n_len;
    logic [ADDR_W-1:0]        r_base, n_base;
    logic [1:0]               r_q, n_q;
    logic [WORD_W-1:0]        r_head, n_head;
    logic                     r_done, n_done;
    t_status                  r_status, n_status;
    logic [1:0]               r_qnum, n_qnum;
    logic [WORD_W-1:0]        r_pop, n_pop;

    logic [3:0]               full, empty;
    t_pick                    pick;
    logic                     accept;

    logic                     ram_we, ram_re;
    logic [ADDR_W-1:0]        ram_waddr, ram_raddr;
    logic [WORD_W-1:0]        ram_wdata, ram_rdata;

    // queue status flags
    always_comb begin
        for (int q = 0; q < 4; q++) begin
            full[q]  = (r_fill[q] == Q_DEPTH[q]);
            empty[q] = (r_fill[q] == '0);
        end
    end

    // priority selection
    sofq_sel u_sel (
        .i_cmd   (i_command),
        .i_full  (full),
        .i_empty (empty),
        .o_pick  (pick)
    );

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    // sequencer and store port control
    always_comb begin
        n_state  = r_state;
        n_fill   = r_fill;
        n_cnt    = r_cnt;
        n_len    = r_len;
        n_base   = r_base;
        n_q      = r_q;
        n_head   = r_head;
        n_done   = 1'b0;
        n_status = r_status;
        n_qnum   = r_qnum;
        n_pop    = r_pop;

        ram_we    = 1'b0;
        ram_waddr = r_base + ADDR_W'(r_cnt - FILL_W'(2));
        ram_wdata = ram_rdata;
        ram_re    = 1'b0;
        ram_raddr = r_base + ADDR_W'(r_cnt);

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (!pick.found) begin
                        // overflow or underflow, nothing changes
                        n_done   = 1'b1;
                        n_status = (i_command == CMD_INSERT) ? ST_OVERFLOW : ST_UNDERFLOW;
                        n_qnum   = '0;
                        n_pop    = '0;
                    end else if (i_command == CMD_INSERT) begin
                        // append at the tail of the chosen queue
                        ram_we    = 1'b1;
                        ram_waddr = Q_BASE[pick.queue] + ADDR_W'(r_fill[pick.queue]);
                        ram_wdata = i_value;
                        n_fill[pick.queue] = r_fill[pick.queue] + FILL_W'(1);
                        n_done   = 1'b1;
                        n_status = ST_DONE;
                        n_qnum   = pick.queue;
                        n_pop    = '0;
                    end else begin
                        // start the read/shift walk over the chosen queue
                        n_state = S_SHIFT;
                        n_cnt   = '0;
                        n_len   = r_fill[pick.queue];
                        n_base  = Q_BASE[pick.queue];
                        n_q     = pick.queue;
                    end
                end
            end
            S_SHIFT: begin
                // read word cnt, data of word cnt-1 arrives now
                ram_re = (r_cnt < r_len);
                if (r_cnt == FILL_W'(1)) begin
                    n_head = ram_rdata;
                end
                ram_we = (r_cnt >= FILL_W'(2));
                n_cnt  = r_cnt + FILL_W'(1);
                if (r_cnt == r_len) begin
                    n_state   = S_IDLE;
                    n_fill[r_q] = r_fill[r_q] - FILL_W'(1);
                    n_done    = 1'b1;
                    n_status  = ST_DONE;
                    n_qnum    = r_q;
                    n_pop     = (r_cnt == FILL_W'(1)) ? ram_rdata : r_head;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            for (int q = 0; q < 4; q++) begin
                r_fill[q] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            r_fill  <= n_fill;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_cnt    <= n_cnt;
        r_len    <= n_len;
        r_base   <= n_base;
        r_q      <= n_q;
        r_head   <= n_head;
        r_status <= n_status;
        r_qnum   <= n_qnum;
        r_pop    <= n_pop;
    end

    // shared word store
    sofq_ram #(
        .WIDTH (WORD_W),
        .DEPTH (STORE_WORDS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // result ports
    assign o_done         = r_done;
    assign o_status       = r_status;
    assign o_queue_number = r_qnum;
    assign o_popped_value = r_pop;

endmodule
